// ----- design/nonlinear_ladder_lowpass_unit_assert.svh -----
// ----------------------------------------------------------------------------
// nonlinear ladder lowpass assertion macros
// concurrent checks, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef NONLINEAR_LADDER_LOWPASS_UNIT_ASSERT_SVH
`define NONLINEAR_LADDER_LOWPASS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NLL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nll assertion failed");

// next-cycle implication
`define NLL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nll assertion failed");

`else

`define NLL_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NLL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/nll_pkg.sv -----
// ----------------------------------------------------------------------------
// nll_pkg
// shared types and codes of the ladder filter
// ----------------------------------------------------------------------------
package nll_pkg;

   localparam int CUTOFF_BITS   = 16;
   localparam int RES_BITS      = 15;
   localparam int OVS_BITS      = 4;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_CUTOFF   = 2'd0;
   localparam logic [1:0] REG_RES      = 2'd1;
   localparam logic [1:0] REG_OVS      = 2'd2;

   localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = 16'h8000;
   localparam logic [RES_BITS-1:0]    RES_RESET    = 15'h0000;
   localparam logic [OVS_BITS-1:0]    OVS_RESET    = 4'h1;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_BSETUP,
      OP_BSTEP,
      OP_BWRITE,
      OP_LOAD,
      OP_FBMUL,
      OP_FBADD,
      OP_TADDR,
      OP_TMUL,
      OP_TFIN,
      OP_SMUL,
      OP_SADD,
      OP_AVG,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] stage;
      logic       aux;
   } dp_cmd_type;

   typedef struct packed {
      logic build_last;
   } dp_status_type;

   typedef enum logic [12:0] {
      ST_BSETUP = 13'b0000000000001,
      ST_BDIV   = 13'b0000000000010,
      ST_BWRITE = 13'b0000000000100,
      ST_IDLE   = 13'b0000000001000,
      ST_FBM    = 13'b0000000010000,
      ST_FBA    = 13'b0000000100000,
      ST_TA     = 13'b0000001000000,
      ST_TB     = 13'b0000010000000,
      ST_TC     = 13'b0000100000000,
      ST_SM     = 13'b0001000000000,
      ST_SA     = 13'b0010000000000,
      ST_AVG    = 13'b0100000000000,
      ST_DONE   = 13'b1000000000000
   } ctl_state_type;

endpackage

// ----- design/nll_req_if.sv -----
// ----------------------------------------------------------------------------
// nll_req_if
// input sample channel, valid/ready
// ----------------------------------------------------------------------------
interface nll_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- design/nll_rsp_if.sv -----
// ----------------------------------------------------------------------------
// nll_rsp_if
// filtered sample channel, valid/ready
// ----------------------------------------------------------------------------
interface nll_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- design/nll_ctrl.sv -----
// ----------------------------------------------------------------------------
// nll_ctrl
// sequencer: table build after reset, then per-sample filter passes
// ----------------------------------------------------------------------------
module nll_ctrl #(
   parameter int SAMPLE_BITS    = 24,
   parameter int MAX_OVERSAMPLE = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [nll_pkg::OVS_BITS-1:0]  oversample_count,
   input  nll_pkg::dp_status_type        status,
   output nll_pkg::dp_cmd_type           cmd
);
   localparam int QW  = SAMPLE_BITS - 3;
   localparam int DCW = $clog2(QW);
   localparam int PCW = $clog2(MAX_OVERSAMPLE + 1);

   nll_pkg::ctl_state_type state_ff, state_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic [PCW-1:0] pass_ff, pass_in;
   logic [PCW-1:0] npass_ff, npass_in;
   logic [1:0]     stage_ff, stage_in;
   logic           aux_ff, aux_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [4:0]     ovs_ext;
   logic [4:0]     max_ext;
   logic [4:0]     npass_w;

   assign ovs_ext = 5'(oversample_count);
   assign max_ext = 5'(MAX_OVERSAMPLE);
   assign npass_w = (ovs_ext > max_ext) ? max_ext : ovs_ext;

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      pass_in      = pass_ff;
      npass_in     = npass_ff;
      stage_in     = stage_ff;
      aux_in       = aux_ff;
      cmd.op       = nll_pkg::OP_NOP;
      cmd.stage    = stage_ff;
      cmd.aux      = aux_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         nll_pkg::ST_BSETUP: begin
            cmd.op     = nll_pkg::OP_BSETUP;
            div_cnt_in = '0;
            state_in   = nll_pkg::ST_BDIV;
         end
         nll_pkg::ST_BDIV: begin
            cmd.op = nll_pkg::OP_BSTEP;
            if (div_cnt_ff == DCW'(QW - 1)) begin
               state_in = nll_pkg::ST_BWRITE;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         nll_pkg::ST_BWRITE: begin
            cmd.op   = nll_pkg::OP_BWRITE;
            state_in = status.build_last ? nll_pkg::ST_IDLE : nll_pkg::ST_BSETUP;
         end
         nll_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = nll_pkg::OP_LOAD;
               npass_in = PCW'(npass_w);
               pass_in  = '0;
               state_in = (npass_w == 5'd0) ? nll_pkg::ST_DONE : nll_pkg::ST_FBM;
            end
         end
         nll_pkg::ST_FBM: begin
            cmd.op   = nll_pkg::OP_FBMUL;
            state_in = nll_pkg::ST_FBA;
         end
         nll_pkg::ST_FBA: begin
            cmd.op   = nll_pkg::OP_FBADD;
            stage_in = 2'd0;
            aux_in   = 1'b0;
            state_in = nll_pkg::ST_TA;
         end
         nll_pkg::ST_TA: begin
            cmd.op   = nll_pkg::OP_TADDR;
            state_in = nll_pkg::ST_TB;
         end
         nll_pkg::ST_TB: begin
            cmd.op   = nll_pkg::OP_TMUL;
            state_in = nll_pkg::ST_TC;
         end
         nll_pkg::ST_TC: begin
            cmd.op = nll_pkg::OP_TFIN;
            if (aux_ff) begin
               aux_in   = 1'b0;
               state_in = nll_pkg::ST_TA;
            end else begin
               state_in = nll_pkg::ST_SM;
            end
         end
         nll_pkg::ST_SM: begin
            cmd.op   = nll_pkg::OP_SMUL;
            state_in = nll_pkg::ST_SA;
         end
         nll_pkg::ST_SA: begin
            cmd.op = nll_pkg::OP_SADD;
            if (stage_ff == 2'd3) begin
               state_in = nll_pkg::ST_AVG;
            end else begin
               // last stage first needs tanh of its own old value
               stage_in = stage_ff + 2'd1;
               aux_in   = (stage_ff == 2'd2);
               state_in = nll_pkg::ST_TA;
            end
         end
         nll_pkg::ST_AVG: begin
            cmd.op = nll_pkg::OP_AVG;
            if ({1'b0, pass_ff} + 1'b1 == {1'b0, npass_ff}) begin
               state_in = nll_pkg::ST_DONE;
            end else begin
               pass_in  = pass_ff + 1'b1;
               state_in = nll_pkg::ST_FBM;
            end
         end
         nll_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = nll_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = nll_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nll_pkg::ST_BSETUP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nll_pkg::ST_BSETUP;
         div_cnt_ff   <= '0;
         pass_ff      <= '0;
         npass_ff     <= '0;
         stage_ff     <= '0;
         aux_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         pass_ff      <= pass_in;
         npass_ff     <= npass_in;
         stage_ff     <= stage_in;
         aux_ff       <= aux_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/nll_datapath.sv -----
// ----------------------------------------------------------------------------
// nll_datapath
// filter state, shared gain multiplier, tanh table memory and interpolator,
// table builder with a bit-serial divider
// ----------------------------------------------------------------------------
module nll_datapath #(
   parameter int SAMPLE_BITS     = 24,
   parameter int TANH_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  nll_pkg::dp_cmd_type                 cmd,
   input  logic signed [SAMPLE_BITS-1:0]       sample_in,
   input  logic [nll_pkg::CUTOFF_BITS-1:0]     cutoff_gain,
   input  logic [nll_pkg::RES_BITS-1:0]        resonance_gain,
   output nll_pkg::dp_status_type              status,
   output logic signed [SAMPLE_BITS-1:0]       sample_out
);
   localparam int SB   = SAMPLE_BITS;
   localparam int TB   = TANH_TABLE_BITS;
   localparam int FRAC = SB - 4;
   localparam int SEG  = SB - 1 - TB;
   localparam int AW   = TB + 1;
   localparam int TW   = FRAC + 1;
   localparam int QW   = FRAC + 1;
   localparam int DW   = 33 + FRAC + 1;
   localparam int RW   = 35;
   localparam int GW   = nll_pkg::CUTOFF_BITS;
   localparam int MW   = SB + 1;
   localparam int PW   = MW + GW;
   localparam int WW   = PW + 3;
   localparam logic [AW-1:0] LAST_ADDR = AW'(1 << TB);

   // Q32 ratio between neighboring table points of exp(-2x), series sum
   localparam longint BSQ  = 64'sd1 <<< (36 - TB);
   localparam longint BT1  = ((64'sd1 <<< 32) * BSQ) >>> 32;
   localparam longint BT2  = ((BT1 * BSQ) >>> 32) / 2;
   localparam longint BT3  = ((BT2 * BSQ) >>> 32) / 3;
   localparam longint BT4  = ((BT3 * BSQ) >>> 32) / 4;
   localparam longint BT5  = ((BT4 * BSQ) >>> 32) / 5;
   localparam longint BT6  = ((BT5 * BSQ) >>> 32) / 6;
   localparam longint BT7  = ((BT6 * BSQ) >>> 32) / 7;
   localparam longint BT8  = ((BT7 * BSQ) >>> 32) / 8;
   localparam longint BT9  = ((BT8 * BSQ) >>> 32) / 9;
   localparam longint BT10 = ((BT9 * BSQ) >>> 32) / 10;
   localparam longint BT11 = ((BT10 * BSQ) >>> 32) / 11;
   localparam longint BT12 = ((BT11 * BSQ) >>> 32) / 12;
   localparam longint BT13 = ((BT12 * BSQ) >>> 32) / 13;
   localparam longint BT14 = ((BT13 * BSQ) >>> 32) / 14;
   localparam longint BSUM = (64'sd1 <<< 32) - BT1 + BT2 - BT3 + BT4 - BT5 + BT6 - BT7
                           + BT8 - BT9 + BT10 - BT11 + BT12 - BT13 + BT14;
   localparam logic [31:0]   BASE      = 32'(BSUM);
   localparam logic signed [WW-1:0] SMAX_W = {{(WW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [WW-1:0] SMIN_W = {{(WW-SB+1){1'b1}}, {(SB-1){1'b0}}};

   function automatic logic signed [SB-1:0] sat_fn(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] r;
      r = v;
      if (v > SMAX_W) r = SMAX_W;
      if (v < SMIN_W) r = SMIN_W;
      return r[SB-1:0];
   endfunction

   // filter state
   logic signed [SB-1:0] sv_ff [0:3];
   logic signed [SB-1:0] sh_ff [0:2];
   logic signed [SB-1:0] lastprev_ff;
   logic signed [SB-1:0] avg_ff;
   logic signed [SB-1:0] x_ff;
   logic signed [SB-1:0] in_ff;
   logic signed [SB-1:0] t_ff;
   logic signed [SB-1:0] oth_ff;
   logic signed [SB-1:0] out_ff;

   // gain multiplier
   logic [PW-1:0] prod_ff;
   logic          pneg_ff;

   // tanh unit
   logic [TW-1:0]     tanh_mem [0:(1 << TB)];
   logic [TW-1:0]     rd0_ff, rd1_ff;
   logic [SEG-1:0]    fr_ff;
   logic              tneg_ff;
   logic [TW+SEG-1:0] iprod_ff;

   // table builder
   logic [32:0]   u_ff;
   logic [RW-1:0] rem_ff;
   logic [QW-1:0] dsh_ff;
   logic [QW-1:0] q_ff;
   logic [33:0]   den_ff;
   logic [AW-1:0] wr_addr_ff;

   logic signed [SB-1:0] tsel;
   logic [SB-1:0]        tmag;
   logic [AW-1:0]        tidx;
   logic [AW-1:0]        a0, a1;
   logic [TW-1:0]        tdiff;
   logic [TW:0]          ysum;
   logic signed [SB-1:0] yval;

   logic signed [SB-1:0] other;
   logic signed [MW-1:0] mop;
   logic [MW-1:0]        mmag;
   logic [GW-1:0]        mgain;
   logic [PW:0]          rnd_fb, rnd_st;
   logic signed [WW-1:0] sfb, sst;
   logic signed [SB-1:0] svk;
   logic [SB:0]          avg_sum;

   logic [DW-1:0]        bnum;
   logic [33:0]          bden;
   logic [DW-1:0]        bdiv;
   logic [RW-1:0]        r2;
   logic                 ge;
   logic [64:0]          uprod;

   // tanh operand select
   always_comb begin
      if (cmd.aux) begin
         tsel = sv_ff[3];
      end else begin
         case (cmd.stage)
            2'd0:    tsel = in_ff;
            2'd1:    tsel = sv_ff[0];
            2'd2:    tsel = sv_ff[1];
            default: tsel = sv_ff[2];
         endcase
      end
   end

   assign tmag  = tsel[SB-1] ? (~tsel + 1'b1) : tsel;
   assign tidx  = tmag[SB-1:SEG];
   assign a0    = tidx[TB] ? LAST_ADDR : tidx;
   assign a1    = tidx[TB] ? LAST_ADDR : tidx + 1'b1;
   assign tdiff = (rd1_ff > rd0_ff) ? rd1_ff - rd0_ff : '0;
   assign ysum  = {1'b0, rd0_ff}
                + (TW+1)'((iprod_ff + (TW+SEG)'(1 << (SEG - 1))) >> SEG);
   assign yval  = tneg_ff ? -SB'(ysum) : SB'(ysum);

   // stage values and multiplier operand
   always_comb begin
      case (cmd.stage)
         2'd0:    begin other = sh_ff[0]; svk = sv_ff[0]; end
         2'd1:    begin other = sh_ff[1]; svk = sv_ff[1]; end
         2'd2:    begin other = sh_ff[2]; svk = sv_ff[2]; end
         default: begin other = oth_ff;   svk = sv_ff[3]; end
      endcase
      if (cmd.op == nll_pkg::OP_FBMUL) begin
         mop   = {avg_ff[SB-1], avg_ff};
         mgain = {1'b0, resonance_gain};
      end else begin
         mop   = {t_ff[SB-1], t_ff} - {other[SB-1], other};
         mgain = cutoff_gain;
      end
   end

   assign mmag   = mop[MW-1] ? MW'(-mop) : MW'(mop);
   assign rnd_fb = ({1'b0, prod_ff} + (PW+1)'(1 << 12)) >> 13;
   assign rnd_st = ({1'b0, prod_ff} + (PW+1)'(1 << 15)) >> 16;
   assign sfb    = WW'(x_ff) - (pneg_ff ? -$signed({2'b00, rnd_fb}) : $signed({2'b00, rnd_fb}));
   assign sst    = WW'(svk) + (pneg_ff ? -$signed({2'b00, rnd_st}) : $signed({2'b00, rnd_st}));
   assign avg_sum = {sv_ff[3][SB-1], sv_ff[3]} + {lastprev_ff[SB-1], lastprev_ff};

   // table builder arithmetic
   assign bnum  = DW'(34'h1_0000_0000 - {1'b0, u_ff}) << FRAC;
   assign bden  = 34'h1_0000_0000 + {1'b0, u_ff};
   assign bdiv  = bnum + DW'(bden >> 1);
   assign r2    = {rem_ff[RW-2:0], dsh_ff[QW-1]};
   assign ge    = r2 >= {1'b0, den_ff};
   assign uprod = 65'(u_ff) * 65'(BASE) + 65'(33'h0_8000_0000);

   assign status.build_last = (wr_addr_ff == LAST_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) sv_ff[i] <= '0;
         for (int i = 0; i < 3; i++) sh_ff[i] <= '0;
         lastprev_ff <= '0;
         avg_ff      <= '0;
         u_ff        <= 33'h1_0000_0000;
         wr_addr_ff  <= '0;
      end else begin
         case (cmd.op)
            nll_pkg::OP_SADD: begin
               sv_ff[cmd.stage] <= sat_fn(sst);
            end
            nll_pkg::OP_TFIN: begin
               if (!cmd.aux && cmd.stage != 2'd0) begin
                  sh_ff[cmd.stage - 2'd1] <= yval;
               end
            end
            nll_pkg::OP_AVG: begin
               avg_ff      <= avg_sum[SB:1];
               lastprev_ff <= sv_ff[3];
            end
            nll_pkg::OP_BWRITE: begin
               u_ff       <= uprod[64:32];
               wr_addr_ff <= wr_addr_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         nll_pkg::OP_LOAD:  x_ff <= sample_in;
         nll_pkg::OP_FBMUL, nll_pkg::OP_SMUL: begin
            prod_ff <= PW'(mmag) * PW'(mgain);
            pneg_ff <= mop[MW-1];
         end
         nll_pkg::OP_FBADD: in_ff <= sat_fn(sfb);
         nll_pkg::OP_TADDR: begin
            fr_ff   <= tmag[SEG-1:0];
            tneg_ff <= tsel[SB-1];
         end
         nll_pkg::OP_TMUL:  iprod_ff <= (TW+SEG)'(tdiff) * (TW+SEG)'(fr_ff);
         nll_pkg::OP_TFIN: begin
            if (cmd.aux) oth_ff <= yval;
            else t_ff <= yval;
         end
         nll_pkg::OP_OUT:   out_ff <= avg_ff;
         nll_pkg::OP_BSETUP: begin
            rem_ff <= RW'(bdiv[DW-1:QW]);
            dsh_ff <= bdiv[QW-1:0];
            den_ff <= bden;
         end
         nll_pkg::OP_BSTEP: begin
            rem_ff <= ge ? r2 - {1'b0, den_ff} : r2;
            q_ff   <= {q_ff[QW-2:0], ge};
            dsh_ff <= {dsh_ff[QW-2:0], 1'b0};
         end
         default: begin
         end
      endcase
   end

   // table memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.op == nll_pkg::OP_BWRITE) begin
         tanh_mem[wr_addr_ff] <= q_ff;
      end
      if (cmd.op == nll_pkg::OP_TADDR) begin
         rd0_ff <= tanh_mem[a0];
         rd1_ff <= tanh_mem[a1];
      end
   end

   assign sample_out = out_ff;

endmodule

// ----- design/nonlinear_ladder_lowpass_unit.sv -----
// ----------------------------------------------------------------------------
// nonlinear_ladder_lowpass_unit
// four-pole tanh ladder lowpass, fixed point, with apb register port
// ----------------------------------------------------------------------------
//  channel   dir   handshake           payload
//  req_bus   in    valid/ready         sample_in  (signed, SAMPLE_BITS)
//  rsp_bus   out   valid/ready         sample_out (signed, SAMPLE_BITS)
//  csr_*     in    apb, pready high    cutoff, resonance, oversample regs
//
// after reset the tanh table is built: 2^TANH_TABLE_BITS+1 entries, 1025 at
// default, each set up, divided bit-serially and written, no sample taken
// meanwhile. each sample then runs passes = min(oversample_count,
// MAX_OVERSAMPLE) filter passes on the shared multiplier and the tanh unit
// (address, multiply, finish). a transaction waiting at the output stalls
// the next finished result, and no further sample is taken meanwhile.
module nonlinear_ladder_lowpass_unit #(
   parameter int SAMPLE_BITS     = 24,
   parameter int MAX_OVERSAMPLE  = 8,
   parameter int TANH_TABLE_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   nll_req_if.sink                               req_bus,
   nll_rsp_if.source                             rsp_bus,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [nll_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [nll_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [nll_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);
`include "nonlinear_ladder_lowpass_unit_assert.svh"

   logic [nll_pkg::CUTOFF_BITS-1:0] cutoff_ff, cutoff_in;
   logic [nll_pkg::RES_BITS-1:0]    res_ff, res_in;
   logic [nll_pkg::OVS_BITS-1:0]    ovs_ff, ovs_in;
   logic                            csr_wr;
   logic [1:0]                      csr_idx;

   nll_pkg::dp_cmd_type    cmd;
   nll_pkg::dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      cutoff_in  = cutoff_ff;
      res_in     = res_ff;
      ovs_in     = ovs_ff;
      csr_prdata = '0;
      unique case (csr_idx)
         nll_pkg::REG_CUTOFF: begin
            csr_prdata = 32'(cutoff_ff);
            if (csr_wr) cutoff_in = csr_pwdata[nll_pkg::CUTOFF_BITS-1:0];
         end
         nll_pkg::REG_RES: begin
            csr_prdata = 32'(res_ff);
            if (csr_wr) res_in = csr_pwdata[nll_pkg::RES_BITS-1:0];
         end
         nll_pkg::REG_OVS: begin
            csr_prdata = 32'(ovs_ff);
            if (csr_wr) ovs_in = csr_pwdata[nll_pkg::OVS_BITS-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= nll_pkg::CUTOFF_RESET;
         res_ff    <= nll_pkg::RES_RESET;
         ovs_ff    <= nll_pkg::OVS_RESET;
      end else begin
         cutoff_ff <= cutoff_in;
         res_ff    <= res_in;
         ovs_ff    <= ovs_in;
      end
   end

   nll_ctrl #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .MAX_OVERSAMPLE (MAX_OVERSAMPLE)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .oversample_count (ovs_ff),
      .status           (status),
      .cmd              (cmd)
   );

   nll_datapath #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .TANH_TABLE_BITS (TANH_TABLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sample_in      (req_bus.sample_in),
      .cutoff_gain    (cutoff_ff),
      .resonance_gain (res_ff),
      .status         (status),
      .sample_out     (rsp_bus.sample_out)
   );

   `NLL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)
   `NLL_ASSERT_NEXT(a_out_shows_valid, clock, reset, cmd.op == nll_pkg::OP_OUT, rsp_bus.valid)
   `NLL_ASSERT_IMPLY(a_no_load_when_busy, clock, reset, cmd.op == nll_pkg::OP_LOAD, req_bus.ready)
   `NLL_ASSERT_NEXT(a_cutoff_written, clock, reset, csr_wr && csr_idx == nll_pkg::REG_CUTOFF, cutoff_ff == $past(csr_pwdata[15:0]))

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// ladder lowpass bench: samples are filtered by a bit-exact fixed-point copy
// of the four tanh stages and compared with every output transaction, over
// phases of register settings written through the apb port while idle
// ----------------------------------------------------------------------------
module tb;

   localparam int SB          = 24;
   localparam int MAX_PASSES  = 8;
   localparam int TBITS       = 10;
   localparam int FRAC        = SB - 4;
   localparam int TN          = 1 << TBITS;
   localparam int SEG         = SB - 1 - TBITS;
   localparam longint S_HI    = (64'sd1 <<< (SB - 1)) - 1;
   localparam longint S_LO    = -S_HI - 1;
   localparam longint LIMIT   = 2000000;
   localparam int ITEM_TARGET = 1050;

   logic clock = 1'b0;
   logic reset = 1'b1;
   longint cycle_count = 0;

   nll_req_if #(.SAMPLE_BITS(SB)) req_if ();
   nll_rsp_if #(.SAMPLE_BITS(SB)) rsp_if ();

   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [nll_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [nll_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [nll_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   nonlinear_ladder_lowpass_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // filter state mirror
   longint tanh_points [0:TN];
   longint stage_val [4];
   longint stage_tanh [3];
   longint prev_last;
   longint out_avg;
   logic [nll_pkg::CUTOFF_BITS-1:0] gain_cut;
   logic [nll_pkg::RES_BITS-1:0]    gain_res;
   logic [nll_pkg::OVS_BITS-1:0]    pass_count;

   logic signed [SB-1:0] sample_queue [$];
   logic signed [SB-1:0] expected_samples [$];
   int error_count = 0;
   int accepted_count = 0;
   bit req_fire = 1'b0;
   int hold_cycles = 0;
   bit hold_done = 1'b0;

   function automatic void build_tanh_points();
      longint sq, term, sum;
      longint unsigned ratio, u, num, den;
      bit [127:0] prod;
      sq   = 64'sd1 <<< (36 - TBITS);
      term = 64'sd1 <<< 32;
      sum  = term;
      for (int n = 1; n <= 14; n++) begin
         term = ((term * sq) >>> 32) / n;
         if (n % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      ratio = sum;
      u = 64'd1 << 32;
      for (int i = 0; i <= TN; i++) begin
         num = ((64'd1 << 32) - u) << FRAC;
         den = (64'd1 << 32) + u;
         tanh_points[i] = (num + den / 2) / den;
         prod = 128'(u) * 128'(ratio) + (128'd1 << 31);
         u = prod[95:32];
      end
   endfunction

   function automatic longint clip(longint v);
      if (v > S_HI) return S_HI;
      if (v < S_LO) return S_LO;
      return v;
   endfunction

   function automatic longint gain_round(longint a, longint g, int sh);
      longint m, p;
      m = (a < 0) ? -a : a;
      p = (m * g + (64'sd1 <<< (sh - 1))) >>> sh;
      return (a < 0) ? -p : p;
   endfunction

   function automatic longint shaped(longint x);
      longint m, idx, fr, y, d;
      m = (x < 0) ? -x : x;
      idx = m >>> SEG;
      fr = m & ((64'sd1 <<< SEG) - 1);
      if (idx >= TN) begin
         y = tanh_points[TN];
      end else begin
         d = (tanh_points[idx+1] > tanh_points[idx]) ?
             tanh_points[idx+1] - tanh_points[idx] : 0;
         y = tanh_points[idx] + ((d * fr + (64'sd1 <<< (SEG - 1))) >>> SEG);
      end
      return (x < 0) ? -y : y;
   endfunction

   function automatic logic signed [SB-1:0] filter_sample(logic signed [SB-1:0] s);
      longint x, drive, t, other;
      int passes;
      x = s;
      passes = (pass_count > MAX_PASSES) ? MAX_PASSES : pass_count;
      for (int p = 0; p < passes; p++) begin
         drive = clip(x - gain_round(out_avg, gain_res, 13));
         t = shaped(drive);
         stage_val[0] = clip(stage_val[0] + gain_round(t - stage_tanh[0], gain_cut, 16));
         for (int k = 1; k < 4; k++) begin
            t = shaped(stage_val[k-1]);
            stage_tanh[k-1] = t;
            other = (k != 3) ? stage_tanh[k] : shaped(stage_val[3]);
            stage_val[k] = clip(stage_val[k] + gain_round(t - other, gain_cut, 16));
         end
         out_avg = (stage_val[3] + prev_last) >>> 1;
         prev_last = stage_val[3];
      end
      return out_avg[SB-1:0];
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // acceptance and checking
   always @(posedge clock) begin
      req_fire = !reset && req_if.valid && req_if.ready;
      if (req_fire) begin
         expected_samples.push_back(filter_sample(req_if.sample_in));
         accepted_count++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_if.sample_out, 0);
         end else if (rsp_if.sample_out !== expected_samples[0]) begin
            report_mismatch("sample_out", rsp_if.sample_out, expected_samples[0]);
            void'(expected_samples.pop_front());
         end else begin
            void'(expected_samples.pop_front());
         end
      end
   end

   function automatic bit quiet_window();
      return cycle_count >= 60000 && cycle_count < 90000;
   endfunction

   // sample driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (sample_queue.size() > 0 && (quiet_window() || $urandom_range(0, 99) >= 8)) begin
            req_if.sample_in <= sample_queue.pop_front();
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // output acceptor, with one long hold-off
   always @(negedge clock) begin
      if (!hold_done && accepted_count >= 300) begin
         hold_done = 1'b1;
         hold_cycles = 3000;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= quiet_window() || $urandom_range(0, 99) >= 8;
      end
   end

   task automatic csr_write(logic [1:0] index, logic [nll_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         nll_pkg::REG_CUTOFF: gain_cut = value[nll_pkg::CUTOFF_BITS-1:0];
         nll_pkg::REG_RES:    gain_res = value[nll_pkg::RES_BITS-1:0];
         nll_pkg::REG_OVS:    pass_count = value[nll_pkg::OVS_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (sample_queue.size() > 0 || req_if.valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // upper register bits are random and must be ignored
   task automatic set_filter(int cut, int res, int ovs);
      wait_drained();
      csr_write(nll_pkg::REG_CUTOFF, ($urandom() << nll_pkg::CUTOFF_BITS) | cut);
      csr_write(nll_pkg::REG_RES, ($urandom() << nll_pkg::RES_BITS) | res);
      csr_write(nll_pkg::REG_OVS, ($urandom() << nll_pkg::OVS_BITS) | ovs);
   endtask

   function automatic logic signed [SB-1:0] random_sample();
      case ($urandom_range(0, 3))
         0: return SB'($urandom());
         1: return SB'($signed($urandom_range(0, 4095)) - 2048);
         2: return SB'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return ($urandom_range(0, 1)) ? SB'(S_HI) : SB'(S_LO);
      endcase
   endfunction

   initial begin
      int pushed;
      int cut, res, ovs, len;
      logic signed [SB-1:0] level;
      req_if.valid = 1'b0;
      req_if.sample_in = '0;
      rsp_if.ready = 1'b0;
      build_tanh_points();
      gain_cut = nll_pkg::CUTOFF_RESET;
      gain_res = nll_pkg::RES_RESET;
      pass_count = nll_pkg::OVS_RESET;
      for (int k = 0; k < 4; k++) stage_val[k] = 0;
      for (int k = 0; k < 3; k++) stage_tanh[k] = 0;
      prev_last = 0;
      out_avg = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: extremes and a step
      sample_queue = '{24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000, 0, 1, -1,
                       24'sh100000, 24'sh100000, 24'sh100000};
      // full gains and resonance, more passes than supported
      set_filter(65535, 32767, 15);
      sample_queue = '{24'sh7fffff, 24'sh800000, 24'sh7fffff, 0, 24'sh400000};
      // zero passes hold the output
      set_filter(40000, 12000, 0);
      sample_queue = '{24'sh7fffff, 24'sh800000, 24'sh123456};
      // zero cutoff, full passes
      set_filter(0, 0, 8);
      sample_queue = '{24'sh7fffff, 24'sh800000, 5};
      set_filter(65535, 0, 1);
      sample_queue = '{24'sh800000, 24'sh7fffff, 0, 24'sh055555};
      pushed = 25;

      while (pushed < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: cut = 0;
            1: cut = 65535;
            default: cut = $urandom_range(0, 65535);
         endcase
         case ($urandom_range(0, 9))
            0: res = 0;
            1: res = 32767;
            default: res = $urandom_range(0, 36000);
         endcase
         case ($urandom_range(0, 9))
            0: ovs = 0;
            1: ovs = $urandom_range(8, 15);
            default: ovs = $urandom_range(1, 4);
         endcase
         set_filter(cut, res, ovs);
         len = $urandom_range(40, 120);
         level = random_sample();
         for (int i = 0; i < len; i++) begin
            // mostly held levels with small noise, some random jumps
            if ($urandom_range(0, 9) == 0) level = random_sample();
            sample_queue.push_back(SB'(level + $signed($urandom_range(0, 255)) - 128));
         end
         pushed += len;
      end

      wait_drained();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
